FILE: hw/rtl/tsr_pkg.sv
`default_nettype none
package tsr_pkg;
    localparam int PID_COUNT_DEF = 8192;
    localparam logic [12:0] NULL_PID = 13'h1FFF;
    localparam logic [41:0] PCR_MOD = 42'd2576980377600;
    localparam logic [33:0] TS_MOD = 34'h200000000;
    localparam logic [35:0] BITS_CLOCK = 36'd40608000000;
    // ceil(2^39 / 300): exact floor(x / 300) for any x below 2^30
    localparam logic [30:0] RECIP_300 = 31'd1832519380;

    typedef enum logic [1:0] {
        REQ_PACKET = 2'd0,
        REQ_MEMBER = 2'd1,
        REQ_TGT_PCR = 2'd2,
        REQ_REF_PID = 2'd3
    } t_req;

    localparam logic [0:0] CFG_FIXED_REF = 1'b0;
    localparam logic [0:0] CFG_LABEL = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOOK, ST_LOOK2, ST_MUL0, ST_MUL1, ST_MUL2, ST_DIV,
        ST_ADD, ST_SUB, ST_OFS, ST_DIV300, ST_TS, ST_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: hw/rtl/tsr_ram.sv
`default_nettype none
module tsr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/tsr_divider.sv
`default_nettype none
// Restoring divider, 128-bit dividend by 32-bit divisor, one quotient bit per
// cycle; quotient kept reduced modulo PCR_MOD as it is built.
module tsr_divider (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [127:0]  i_num,
    input  wire logic [31:0]   i_den,
    output logic               o_done,
    output logic      [41:0]   o_quot
);
    import tsr_pkg::*;
    logic [127:0] r_num;
    logic [32:0]  r_rem;
    logic [41:0]  r_acc;
    logic [31:0]  r_den;
    logic [7:0]   r_cnt;
    logic         r_busy;
    logic [32:0]  w_rem;
    logic         w_q;
    logic [42:0]  w_acc;
    always_comb begin
        w_rem = {r_rem[31:0], r_num[127]};
        w_q = w_rem >= {1'b0, r_den};
        if (w_q) w_rem = w_rem - {1'b0, r_den};
        w_acc = {r_acc, w_q};
        if (w_acc >= {1'b0, PCR_MOD}) w_acc = w_acc - {1'b0, PCR_MOD};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 8'd0;
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_acc <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[126:0], 1'b0};
                r_rem <= w_rem;
                r_acc <= w_acc[41:0];
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd127) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_acc;
endmodule
`default_nettype wire

FILE: hw/rtl/ts_service_clock_restamper_unit.sv
`default_nettype none
// Service clock restamper. One input beat per packet or event on the i_ channel;
// packet beats yield one result beat, events none. Config writes by
// i_cfg_we/i_cfg_index/i_cfg_data while idle.
// After reset a clearing pass runs over every entry of both PID bit memories;
// o_ready stays low meanwhile (config writes still taken).
// Items are handled one at a time. An event goes from ST_LOOK straight back to
// ST_IDLE. A packet with no PCR rewrite passes ST_LOOK, ST_LOOK2 and ST_TS before
// o_valid rises in ST_OUT. A PCR rewrite with zero bitrate adds ST_SUB, ST_DIV300
// and ST_OFS; a nonzero one also adds ST_MUL0..ST_MUL2, the bit-serial divider in
// ST_DIV and ST_ADD. The /300 of the offset is two reciprocal multiplies. o_ready
// returns the cycle after the result beat is taken.
// A result waits in the output register while o_valid is high and o_ready is
// held low until it is taken, so a stalled receiver stalls the sender.
module ts_service_clock_restamper_unit #(
    parameter int PID_COUNT = tsr_pkg::PID_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [12:0] i_pid,
    input  wire logic        i_member,
    input  wire logic        i_has_pcr,
    input  wire logic [41:0] i_pcr_in,
    input  wire logic        i_has_pts,
    input  wire logic [32:0] i_pts_in,
    input  wire logic        i_has_dts,
    input  wire logic [32:0] i_dts_in,
    input  wire logic [31:0] i_stream_bitrate,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [41:0]      o_pcr_out,
    output logic             o_pcr_rewritten,
    output logic [32:0]      o_pts_out,
    output logic             o_pts_rewritten,
    output logic [32:0]      o_dts_out,
    output logic             o_dts_rewritten,
    output logic             o_apply_labels
);
    import tsr_pkg::*;

    localparam int AW = $clog2(PID_COUNT);

    t_state r_state, n_state;
    logic [12:0] r_fixed_ref, r_cur_ref, r_tgt_pcr;
    logic [31:0] r_label;
    logic [41:0] r_ref_pcr;
    logic        r_ref_valid;
    logic [47:0] r_ref_idx, r_pkt_idx;
    logic [33:0] r_ofs;
    logic [AW-1:0] r_clr;
    // held item
    t_req        r_req;
    logic [12:0] r_pid;
    logic        r_member, r_has_pcr, r_has_pts, r_has_dts;
    logic [41:0] r_pcr_in, r_ref;
    logic [32:0] r_pts_in, r_dts_in;
    logic [31:0] r_rate;
    logic [47:0] r_d;
    logic [71:0] r_plo, r_phi;
    logic        r_tgt, r_mod;
    logic [41:0] r_diff;
    logic        r_ge;
    logic [29:0] r_drem;
    logic [32:0] r_dq;
    logic [5:0]  r_dcnt;

    logic        w_tgt_rd, w_mod_rd;
    logic        w_tgt_we, w_mod_we, w_tgt_wd;
    logic [AW-1:0] w_tgt_wa, w_mod_wa;
    logic        w_div_start, w_div_done;
    logic [41:0] w_quot;
    logic [127:0] w_num;
    logic [42:0] w_sum;
    logic [41:0] w_ref_red, w_p_red;
    logic [29:0] w_rop;
    logic [60:0] w_rprod;
    logic [21:0] w_rq;
    logic [20:0] w_r1;

    tsr_ram #(.WIDTH(1), .DEPTH(PID_COUNT)) u_tgt (
        .i_clk, .i_we(w_tgt_we), .i_waddr(w_tgt_wa), .i_wdata(w_tgt_wd),
        .i_raddr(i_pid[AW-1:0]), .o_rdata(w_tgt_rd));
    tsr_ram #(.WIDTH(1), .DEPTH(PID_COUNT)) u_mod (
        .i_clk, .i_we(w_mod_we), .i_waddr(w_mod_wa), .i_wdata(r_state != ST_CLEAR),
        .i_raddr(i_pid[AW-1:0]), .o_rdata(w_mod_rd));
    tsr_divider u_div (
        .i_clk, .i_rst_n, .i_start(w_div_start), .i_num(w_num), .i_den(r_rate),
        .o_done(w_div_done), .o_quot(w_quot));

    // 48x36 product built from two 24x36 partials
    assign w_num = {56'd0, r_phi} * 128'd16777216 + {56'd0, r_plo};
    assign w_ref_red = (r_ref_pcr >= PCR_MOD) ? r_ref_pcr - PCR_MOD : r_ref_pcr;
    assign w_p_red = (r_pcr_in >= PCR_MOD) ? r_pcr_in - PCR_MOD : r_pcr_in;
    assign w_sum = {1'b0, r_ref} + {1'b0, w_quot};

    // diff/300 as two 21-bit digits: high digit, its remainder, then low digit
    assign w_rop = (r_dcnt == 6'd0) ? {9'd0, r_diff[41:21]} : r_drem;
    assign w_rprod = 61'(w_rop) * 61'(RECIP_300);
    assign w_rq = w_rprod[60:39];
    assign w_r1 = r_diff[41:21] - r_dq[20:0] * 21'd300;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == AW'(PID_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_valid) n_state = ST_LOOK;
            ST_LOOK:  n_state = (r_req == REQ_PACKET) ? ST_LOOK2 : ST_IDLE;
            ST_LOOK2: begin
                if (r_tgt && r_has_pcr)
                    n_state = (r_rate != 32'd0) ? ST_MUL0 : ST_SUB;
                else n_state = ST_TS;
            end
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_ADD;
            ST_ADD:  n_state = ST_SUB;
            ST_SUB:  n_state = ST_DIV300;
            ST_DIV300: if (r_dcnt == 6'd2) n_state = ST_OFS;
            ST_OFS:  n_state = ST_TS;
            ST_TS:   n_state = ST_OUT;
            ST_OUT:  if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = r_state == ST_IDLE;
        o_valid = r_state == ST_OUT;
        w_div_start = r_state == ST_MUL2;
        w_tgt_we = 1'b0;
        w_tgt_wa = r_pid[AW-1:0];
        w_tgt_wd = 1'b0;
        w_mod_we = 1'b0;
        w_mod_wa = r_pid[AW-1:0];
        case (r_state)
            ST_CLEAR: begin
                w_tgt_we = 1'b1; w_mod_we = 1'b1;
                w_tgt_wa = r_clr; w_mod_wa = r_clr;
            end
            ST_LOOK: begin
                if (r_req == REQ_MEMBER) begin
                    w_tgt_we = 1'b1; w_tgt_wd = r_member;
                end else if (r_req == REQ_TGT_PCR) begin
                    w_tgt_we = 1'b1; w_tgt_wd = 1'b1;
                end
            end
            ST_TS: w_mod_we = r_tgt && (r_has_pcr || r_has_pts || r_has_dts);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_fixed_ref <= NULL_PID;
            r_cur_ref <= NULL_PID;
            r_label <= '0;
            r_ref_pcr <= '0;
            r_ref_valid <= 1'b0;
            r_ref_idx <= '0;
            r_pkt_idx <= '0;
            r_ofs <= '0;
            r_tgt_pcr <= NULL_PID;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIXED_REF: begin
                        r_fixed_ref <= i_cfg_data[12:0];
                        r_cur_ref <= i_cfg_data[12:0];
                        r_ref_valid <= 1'b0;
                        r_ref_pcr <= '0;
                        r_ref_idx <= '0;
                    end
                    CFG_LABEL: r_label <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_LOOK: begin
                    if (r_req == REQ_TGT_PCR && r_pid != r_tgt_pcr) begin
                        r_ofs <= '0; r_tgt_pcr <= r_pid;
                    end
                    if (r_req == REQ_REF_PID && r_fixed_ref == NULL_PID &&
                        r_pid != NULL_PID && r_pid != r_cur_ref) begin
                        r_cur_ref <= r_pid;
                        r_ref_valid <= 1'b0; r_ref_pcr <= '0; r_ref_idx <= '0;
                    end
                    if (r_req == REQ_PACKET) begin
                        if (r_cur_ref != NULL_PID && r_pid == r_cur_ref && r_has_pcr) begin
                            r_ref_pcr <= r_pcr_in;
                            r_ref_idx <= r_pkt_idx;
                            r_ref_valid <= 1'b1;
                            r_d <= '0;
                        end else begin
                            r_d <= r_pkt_idx - r_ref_idx;
                        end
                        r_tgt <= w_tgt_rd && (r_ref_valid ||
                            (r_cur_ref != NULL_PID && r_pid == r_cur_ref && r_has_pcr));
                    end
                end
                ST_LOOK2: r_ref <= w_ref_red;
                ST_MUL0: r_plo <= 72'(r_d[23:0]) * 72'(BITS_CLOCK);
                ST_MUL1: r_phi <= 72'(r_d[47:24]) * 72'(BITS_CLOCK);
                ST_ADD: r_ref <= (w_sum >= {1'b0, PCR_MOD}) ? 42'(w_sum - {1'b0, PCR_MOD})
                                                           : w_sum[41:0];
                ST_SUB: begin
                    r_ge <= r_ref >= w_p_red;
                    r_diff <= (r_ref >= w_p_red) ? r_ref - w_p_red : w_p_red - r_ref;
                    r_drem <= '0;
                    r_dq <= '0;
                    r_dcnt <= '0;
                end
                ST_DIV300: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    case (r_dcnt)
                        6'd0: r_dq <= {11'd0, w_rq};
                        6'd1: r_drem <= {w_r1[8:0], r_diff[20:0]};
                        default: r_dq <= {r_dq[11:0], w_rq[20:0]};
                    endcase
                end
                ST_OFS: r_ofs <= r_ge ? {1'b0, r_dq} : TS_MOD - {1'b0, r_dq};
                ST_TS: begin
                    o_pcr_out <= (r_tgt && r_has_pcr) ? r_ref : r_pcr_in;
                    o_pcr_rewritten <= r_tgt && r_has_pcr;
                    o_pts_out <= (r_tgt && r_has_pts) ? 33'(r_pts_in + r_ofs[32:0]) : r_pts_in;
                    o_pts_rewritten <= r_tgt && r_has_pts;
                    o_dts_out <= (r_tgt && r_has_dts) ? 33'(r_dts_in + r_ofs[32:0]) : r_dts_in;
                    o_dts_rewritten <= r_tgt && r_has_dts;
                    o_apply_labels <= (r_label != 32'd0) &&
                        (r_mod || (r_tgt && (r_has_pcr || r_has_pts || r_has_dts)));
                    r_pkt_idx <= r_pkt_idx + 48'd1;
                end
                default: ;
            endcase
        end
    end

    // item capture; memory read data lands in ST_LOOK
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_req <= t_req'(i_req_type);
            r_pid <= i_pid;
            r_member <= i_member;
            r_has_pcr <= i_has_pcr;
            r_pcr_in <= i_pcr_in;
            r_has_pts <= i_has_pts;
            r_pts_in <= i_pts_in;
            r_has_dts <= i_has_dts;
            r_dts_in <= i_dts_in;
            r_rate <= i_stream_bitrate;
        end
        if (r_state == ST_LOOK) r_mod <= w_mod_rd;
    end
endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import tsr_pkg::*;

    typedef struct packed {
        t_req        req;
        logic [12:0] pid;
        logic        member;
        logic        has_pcr;
        logic [41:0] pcr;
        logic        has_pts;
        logic [32:0] pts;
        logic        has_dts;
        logic [32:0] dts;
        logic [31:0] bitrate;
    } pkt_t;

    typedef struct packed {
        logic [41:0] pcr;
        logic        pcr_rw;
        logic [32:0] pts;
        logic        pts_rw;
        logic [32:0] dts;
        logic        dts_rw;
        logic        labels;
    } stamp_t;

    typedef struct {
        pkt_t   p;
        bit     typed;
        stamp_t s;
    } row_t;

    localparam logic [41:0] PCR_WRAP = 42'd2576980377600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_FIXED_REF;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = REQ_PACKET;
    logic [12:0] i_pid = '0;
    logic        i_member = 1'b0;
    logic        i_has_pcr = 1'b0;
    logic [41:0] i_pcr_in = '0;
    logic        i_has_pts = 1'b0;
    logic [32:0] i_pts_in = '0;
    logic        i_has_dts = 1'b0;
    logic [32:0] i_dts_in = '0;
    logic [31:0] i_stream_bitrate = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [41:0] o_pcr_out;
    logic        o_pcr_rewritten;
    logic [32:0] o_pts_out;
    logic        o_pts_rewritten;
    logic [32:0] o_dts_out;
    logic        o_dts_rewritten;
    logic        o_apply_labels;

    ts_service_clock_restamper_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

    // shadow of the block
    logic [12:0] m_fixed_ref = NULL_PID;
    logic [31:0] m_labels = '0;
    logic [12:0] m_ref_pid = NULL_PID;
    logic [41:0] m_ref_pcr = '0;
    bit          m_ref_ok = 0;
    logic [47:0] m_ref_idx = '0;
    logic [47:0] m_idx = '0;
    logic [33:0] m_ofs = '0;
    logic [12:0] m_tgt_pcr_pid = NULL_PID;
    bit          m_target[8192];
    bit          m_touched[8192];

    stamp_t stamps_due[$];
    int     errors = 0;
    bit     quiet = 0;
    int     rx_hold = 0;
    bit     long_stall = 0;
    bit     long_done = 0;

    function automatic logic [41:0] wrap_pcr(logic [42:0] v);
        return 42'((v >= PCR_WRAP) ? v - PCR_WRAP : v);
    endfunction

    function automatic bit restamp(pkt_t p, output stamp_t s);
        logic [127:0] prod;
        logic [41:0] ref_v, pv;
        s = '{pcr: p.pcr, pcr_rw: 0, pts: p.pts, pts_rw: 0, dts: p.dts, dts_rw: 0,
              labels: 0};
        case (p.req)
            REQ_MEMBER: begin
                m_target[p.pid] = p.member;
                return 0;
            end
            REQ_TGT_PCR: begin
                m_target[p.pid] = 1;
                if (p.pid != m_tgt_pcr_pid) begin
                    m_ofs = '0;
                    m_tgt_pcr_pid = p.pid;
                end
                return 0;
            end
            REQ_REF_PID: begin
                if (m_fixed_ref == NULL_PID && p.pid != NULL_PID && p.pid != m_ref_pid) begin
                    m_ref_pid = p.pid;
                    m_ref_ok = 0;
                    m_ref_pcr = '0;
                    m_ref_idx = '0;
                end
                return 0;
            end
            default: ;
        endcase
        if (m_ref_pid != NULL_PID && p.pid == m_ref_pid && p.has_pcr) begin
            m_ref_pcr = p.pcr;
            m_ref_idx = m_idx;
            m_ref_ok = 1;
        end
        if (m_ref_ok && m_target[p.pid]) begin
            if (p.has_pcr) begin
                // 42-bit values can hold less than two wraps
                ref_v = wrap_pcr(wrap_pcr(m_ref_pcr));
                pv = wrap_pcr(wrap_pcr(p.pcr));
                if (p.bitrate != 0) begin
                    prod = 128'(48'(m_idx - m_ref_idx)) * 128'd40608000000;
                    prod = (prod / p.bitrate) % PCR_WRAP;
                    ref_v = wrap_pcr({1'b0, ref_v} + prod[42:0]);
                end
                if (ref_v >= pv) m_ofs = 34'((ref_v - pv) / 300);
                else m_ofs = 34'h200000000 - 34'((pv - ref_v) / 300);
                s.pcr = ref_v;
                s.pcr_rw = 1;
                m_touched[p.pid] = 1;
            end
            if (p.has_pts) begin
                s.pts = 33'(p.pts + m_ofs);
                s.pts_rw = 1;
                m_touched[p.pid] = 1;
            end
            if (p.has_dts) begin
                s.dts = 33'(p.dts + m_ofs);
                s.dts_rw = 1;
                m_touched[p.pid] = 1;
            end
        end
        m_idx = m_idx + 48'd1;
        s.labels = (m_labels != 0) && m_touched[p.pid];
        return 1;
    endfunction

    task automatic settle;
        wait (stamps_due.size() == 0);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        settle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FIXED_REF) begin
            m_fixed_ref = val[12:0];
            m_ref_pid = val[12:0];
            m_ref_ok = 0;
            m_ref_pcr = '0;
            m_ref_idx = '0;
        end else begin
            m_labels = val;
        end
    endtask

    // drive one beat and hold it until taken; typed rows override the prediction
    task automatic send(pkt_t p, bit typed = 0, stamp_t typed_s = '0);
        stamp_t s;
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= p.req;
        i_pid <= p.pid;
        i_member <= p.member;
        i_has_pcr <= p.has_pcr;
        i_pcr_in <= p.pcr;
        i_has_pts <= p.has_pts;
        i_pts_in <= p.pts;
        i_has_dts <= p.has_dts;
        i_dts_in <= p.dts;
        i_stream_bitrate <= p.bitrate;
        do @(posedge i_clk); while (!o_ready);
        if (restamp(p, s)) stamps_due.push_back(typed ? typed_s : s);
    endtask

    function automatic pkt_t ev(t_req r, logic [12:0] pid, logic mem = 0);
        pkt_t p = '0;
        p.req = r;
        p.pid = pid;
        p.member = mem;
        return p;
    endfunction

    function automatic pkt_t pk(logic [12:0] pid, logic hc, logic [41:0] pcr, logic hp,
                                logic [32:0] pts, logic hd, logic [32:0] dts,
                                logic [31:0] br);
        return '{REQ_PACKET, pid, 1'b0, hc, pcr, hp, pts, hd, dts, br};
    endfunction

    function automatic pkt_t rand_pkt();
        logic [12:0] pool[8] = '{13'd0, 13'd1, 13'd2, 13'd50, 13'd60, 13'd61, NULL_PID,
                                 13'h1555};
        pkt_t p;
        int k;
        p.pid = ($urandom_range(0, 9) == 0) ? 13'($urandom) : pool[$urandom_range(0, 7)];
        k = $urandom_range(0, 19);
        p.req = (k < 14) ? REQ_PACKET : (k < 17) ? REQ_MEMBER : (k < 18) ? REQ_TGT_PCR
              : REQ_REF_PID;
        p.member = 1'($urandom);
        p.has_pcr = 1'($urandom);
        p.pcr = 42'({$urandom, $urandom});
        if ($urandom_range(0, 7) != 0) p.pcr = p.pcr % PCR_WRAP;
        p.has_pts = 1'($urandom);
        p.pts = 33'({$urandom, $urandom});
        p.has_dts = 1'($urandom);
        p.dts = 33'({$urandom, $urandom});
        k = $urandom_range(0, 3);
        p.bitrate = (k == 0) ? 32'd0 : (k == 1) ? 32'($urandom_range(1, 5000)) : $urandom;
        return p;
    endfunction

    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (long_stall && !long_done) begin
            long_done <= 1'b1;
            rx_hold <= 400;
            i_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= (rx_hold == 1);
        end else if (o_valid && i_ready) begin
            hold = quiet ? 0 : $urandom_range(0, 14);
            rx_hold <= hold;
            i_ready <= (hold == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        stamp_t g;
        if (i_rst_n && o_valid && i_ready) begin
            if (stamps_due.size() == 0) begin
                $error("result beat with nothing outstanding");
                errors++;
            end else begin
                g = stamps_due.pop_front();
                if (o_pcr_out !== g.pcr) begin
                    $error("pcr_out exp %0d got %0d", g.pcr, o_pcr_out); errors++;
                end
                if (o_pcr_rewritten !== g.pcr_rw) begin
                    $error("pcr_rewritten exp %0d got %0d", g.pcr_rw, o_pcr_rewritten);
                    errors++;
                end
                if (o_pts_out !== g.pts) begin
                    $error("pts_out exp %0d got %0d", g.pts, o_pts_out); errors++;
                end
                if (o_pts_rewritten !== g.pts_rw) begin
                    $error("pts_rewritten exp %0d got %0d", g.pts_rw, o_pts_rewritten);
                    errors++;
                end
                if (o_dts_out !== g.dts) begin
                    $error("dts_out exp %0d got %0d", g.dts, o_dts_out); errors++;
                end
                if (o_dts_rewritten !== g.dts_rw) begin
                    $error("dts_rewritten exp %0d got %0d", g.dts_rw, o_dts_rewritten);
                    errors++;
                end
                if (o_apply_labels !== g.labels) begin
                    $error("apply_labels exp %0d got %0d", g.labels, o_apply_labels);
                    errors++;
                end
            end
        end
    end

    initial begin
        row_t rows[$];
        logic [31:0] masks[5] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h0};
        logic [12:0] refs[5] = '{NULL_PID, NULL_PID, 13'd50, 13'd0, NULL_PID};
        for (int i = 0; i < 8192; i++) begin
            m_target[i] = 0;
            m_touched[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing targeted yet: full-scale fields pass straight through
        rows.push_back('{pk(13'd100, 1, '1, 1, '1, 1, '1, '1), 1,
                         '{'1, 0, '1, 0, '1, 0, 0}});
        rows.push_back('{ev(REQ_REF_PID, NULL_PID), 0, '0});
        rows.push_back('{pk(NULL_PID, 1, 42'd0, 1, 33'd0, 1, 33'd0, 32'd0), 1,
                         '{42'd0, 0, 33'd0, 0, 33'd0, 0, 0}});
        rows.push_back('{ev(REQ_REF_PID, 13'd50), 0, '0});
        rows.push_back('{ev(REQ_TGT_PCR, 13'd60), 0, '0});
        rows.push_back('{ev(REQ_MEMBER, 13'd61, 1), 0, '0});
        rows.push_back('{pk(13'd60, 1, 42'd999, 1, 33'd5, 0, 33'd0, 32'd0), 0, '0});
        // PCR above the wrap point on the reference
        rows.push_back('{pk(13'd50, 1, '1, 0, 33'd0, 0, 33'd0, 32'd0), 0, '0});
        rows.push_back('{pk(13'd60, 1, 42'd0, 1, '1, 1, 33'd0, 32'd0), 0, '0});
        rows.push_back('{pk(13'd61, 0, 42'd0, 1, 33'd7, 1, '1, '1), 0, '0});
        rows.push_back('{pk(13'd60, 1, '1, 1, 33'd1, 1, 33'd2, 32'd1), 0, '0});
        rows.push_back('{pk(13'd60, 1, PCR_WRAP - 1, 0, 33'd0, 1, 33'd3, '1), 0, '0});
        rows.push_back('{ev(REQ_MEMBER, 13'd50, 1), 0, '0});
        // reference and target in one packet
        rows.push_back('{pk(13'd50, 1, 42'd123456, 1, 33'd9, 1, 33'd9, 32'd38000000), 0, '0});
        rows.push_back('{ev(REQ_TGT_PCR, 13'd60), 0, '0});
        rows.push_back('{pk(13'd61, 0, 42'd0, 1, 33'd0, 0, 33'd0, 32'd0), 0, '0});
        rows.push_back('{ev(REQ_TGT_PCR, NULL_PID), 0, '0});
        rows.push_back('{pk(13'd61, 0, 42'd0, 1, 33'd0, 1, 33'd0, 32'd0), 0, '0});
        rows.push_back('{ev(REQ_MEMBER, 13'd61, 0), 0, '0});
        rows.push_back('{pk(13'd61, 1, 42'd77, 1, 33'd8, 0, 33'd0, 32'd0), 0, '0});
        rows.push_back('{ev(REQ_REF_PID, 13'd50), 0, '0});
        rows.push_back('{ev(REQ_REF_PID, 13'd0), 0, '0});
        rows.push_back('{pk(13'd0, 1, 42'd0, 0, 33'd0, 0, 33'd0, 32'd0), 0, '0});
        foreach (rows[i]) send(rows[i].p, rows[i].typed, rows[i].s);
        i_valid <= 1'b0;

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_LABEL, masks[ph] | ((ph == 3) ? $urandom : 32'h0));
            write_reg(CFG_FIXED_REF, {19'd0, refs[ph]});
            for (int n = 0; n < 385; n++) begin
                quiet = (n < 60) || (n >= 200 && n < 240);
                if (ph == 1 && n == 10) long_stall = 1;
                send(rand_pkt());
            end
            i_valid <= 1'b0;
        end

        wait (stamps_due.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
